>>> rtl/core/assert_macros.svh
// assertion macros for the rtl files
// expects a clock named clock and a synchronous reset named reset in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds -> consequent holds in the same cycle
`define BPA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds -> consequent holds in the next cycle
`define BPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/bpa_pkg.sv
// shared constants and types for the bitmap page allocator
// no dependencies
package bpa_pkg;

   localparam int MAX_PAGES     = 4096;
   localparam int BITS_PER_WORD = 32;
   localparam int PAGE_SHIFT    = 12;

   localparam int ADDR_W      = 32;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 13;
   localparam int WORD_COUNT  = (MAX_PAGES + BITS_PER_WORD - 1) / BITS_PER_WORD;
   localparam int WORD_IDX_W  = $clog2(WORD_COUNT);
   localparam int BIT_IDX_W   = $clog2(BITS_PER_WORD);
   localparam int PAGE_NUM_W  = ADDR_W - PAGE_SHIFT;
   localparam int WORD_SEL_W  = COUNT_W - BIT_IDX_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_FREE    = 2'd1,
      CMD_RESERVE = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_NO_FREE = 2'd1,
      STATUS_REJECT  = 2'd2
   } status_type;

endpackage

>>> rtl/core/bpa_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module bpa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bitmap_page_allocator_top.sv
// bitmap page allocator: one used bit per page held in a bitmap ram, plus a used count
// depends on bpa_pkg, bpa_ram and assert_macros.svh
//
//  channel  ports                                   handshake
//  request  req_cmd, req_page_address               start high while busy low
//  response rsp_status, rsp_result_address,         rsp_strobe, one cycle, no stall
//           rsp_used_count, rsp_free_count
//  config   csr_wr_data                             csr_wr_en, write only
//
// free and reserve read the addressed bitmap word, check and update it, then register the strobe
// allocate scans 1..128 bitmap words from word 0 until one has a free bit or the last
// word is reached, one word per cycle from the bitmap ram read port
// out-of-range requests, unknown commands and allocate with zero pages answer next cycle
// reset clears the row valid bits at once; a row never written reads as all free
// busy drops in the cycle the strobe is shown, so a new item may start then
`include "assert_macros.svh"

module bitmap_page_allocator_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [bpa_pkg::CMD_W-1:0]     req_cmd,
   input  logic [bpa_pkg::ADDR_W-1:0]    req_page_address,
   output logic                          rsp_strobe,
   output logic [bpa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [bpa_pkg::ADDR_W-1:0]    rsp_result_address,
   output logic [bpa_pkg::COUNT_W-1:0]   rsp_used_count,
   output logic [bpa_pkg::COUNT_W-1:0]   rsp_free_count,
   input  logic                          csr_wr_en,
   input  logic [bpa_pkg::COUNT_W-1:0]   csr_wr_data
);
   import bpa_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_CHECK
   } state_type;

   state_type                 state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [WORD_IDX_W-1:0]     word_ff, word_in;
   logic [WORD_IDX_W-1:0]     rd_word_ff, rd_word_in;
   logic [BIT_IDX_W-1:0]      bit_ff, bit_in;
   logic [COUNT_W-1:0]        used_ff, used_in;
   logic [COUNT_W-1:0]        total_ff;
   logic [WORD_COUNT-1:0]     row_valid_ff;
   logic                      rd_valid_ff;

   logic                      rsp_strobe_ff, rsp_strobe_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]         rsp_addr_ff, rsp_addr_in;
   logic [COUNT_W-1:0]        rsp_used_ff;
   logic [COUNT_W-1:0]        rsp_free_ff;

   logic                      accept;
   logic [COUNT_W-1:0]        total_eff;
   logic [COUNT_W-1:0]        total_m1;
   logic [WORD_IDX_W-1:0]     last_word;
   logic [PAGE_NUM_W-1:0]     req_page;
   logic                      req_in_range;

   logic                      ram_wr_en;
   logic [BITS_PER_WORD-1:0]  ram_wr_data;
   logic                      ram_rd_en;
   logic [WORD_IDX_W-1:0]     ram_rd_addr;
   logic [BITS_PER_WORD-1:0]  ram_rd_data;

   logic [BITS_PER_WORD-1:0]  cur_word;
   logic [BITS_PER_WORD-1:0]  range_mask;
   logic [BITS_PER_WORD-1:0]  free_bits;
   logic [BIT_IDX_W-1:0]      free_idx;
   logic [BITS_PER_WORD-1:0]  free_onehot;
   logic [BITS_PER_WORD-1:0]  sel_onehot;
   logic [WORD_SEL_W-1:0]     full_words;
   logic [WORD_SEL_W-1:0]     rd_word_ext;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign total_eff = (total_ff > COUNT_W'(MAX_PAGES)) ? COUNT_W'(MAX_PAGES) : total_ff;
   assign total_m1  = total_eff - COUNT_W'(1);
   assign last_word = total_m1[BIT_IDX_W +: WORD_IDX_W];
   assign req_page  = req_page_address[ADDR_W-1:PAGE_SHIFT];
   assign req_in_range = (req_page < PAGE_NUM_W'(total_eff));

   // rows never written since reset read as all free
   assign cur_word = rd_valid_ff ? ram_rd_data : '0;

   // pages at or above the total count as used in the scan
   assign full_words  = total_eff[COUNT_W-1:BIT_IDX_W];
   assign rd_word_ext = WORD_SEL_W'(rd_word_ff);
   always_comb begin
      if (rd_word_ext < full_words) begin
         range_mask = '1;
      end else if (rd_word_ext == full_words) begin
         range_mask = (BITS_PER_WORD'(1) << total_eff[BIT_IDX_W-1:0]) - BITS_PER_WORD'(1);
      end else begin
         range_mask = '0;
      end
   end

   assign free_bits = ~cur_word & range_mask;

   // lowest free bit
   always_comb begin
      free_idx = '0;
      for (int i = BITS_PER_WORD - 1; i >= 0; i--) begin
         if (free_bits[i]) begin
            free_idx = BIT_IDX_W'(i);
         end
      end
   end

   assign free_onehot = BITS_PER_WORD'(1) << free_idx;
   assign sel_onehot  = BITS_PER_WORD'(1) << bit_ff;

   // read port: one word per cycle while scanning
   assign ram_rd_en   = (state_ff == S_READ) || (state_ff == S_CHECK);
   assign ram_rd_addr = word_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      word_in       = word_ff;
      rd_word_in    = rd_word_ff;
      bit_in        = bit_ff;
      used_in       = used_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STATUS_REJECT;
      rsp_addr_in   = '0;
      ram_wr_en     = 1'b0;
      ram_wr_data   = cur_word;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in  = cmd_type'(req_cmd);
               word_in = req_page[BIT_IDX_W +: WORD_IDX_W];
               bit_in  = req_page[BIT_IDX_W-1:0];
               case (cmd_type'(req_cmd))
                  CMD_ALLOC: begin
                     word_in = '0;
                     if (total_eff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_status_in = STATUS_NO_FREE;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  CMD_FREE, CMD_RESERVE: begin
                     if (req_in_range) begin
                        state_in = S_READ;
                     end else begin
                        rsp_strobe_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_READ: begin
            rd_word_in = word_ff;
            word_in    = word_ff + WORD_IDX_W'(1);
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (free_bits != '0) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_data   = cur_word | free_onehot;
                     used_in       = used_ff + COUNT_W'(1);
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_DONE;
                     rsp_addr_in   = ADDR_W'({rd_word_ff, free_idx}) << PAGE_SHIFT;
                     state_in      = S_IDLE;
                  end else if (rd_word_ff == last_word) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = STATUS_NO_FREE;
                     state_in      = S_IDLE;
                  end else begin
                     rd_word_in = word_ff;
                     word_in    = word_ff + WORD_IDX_W'(1);
                  end
               end
               CMD_FREE: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
                  if (cur_word[bit_ff]) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_data   = cur_word & ~sel_onehot;
                     used_in       = (used_ff != '0) ? used_ff - COUNT_W'(1) : used_ff;
                     rsp_status_in = STATUS_DONE;
                  end
               end
               CMD_RESERVE: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
                  if (!cur_word[bit_ff]) begin
                     ram_wr_en     = 1'b1;
                     ram_wr_data   = cur_word | sel_onehot;
                     used_in       = used_ff + COUNT_W'(1);
                     rsp_status_in = STATUS_DONE;
                  end
               end
               default: begin
                  rsp_strobe_in = 1'b1;
                  state_in      = S_IDLE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         used_ff       <= '0;
         total_ff      <= COUNT_W'(MAX_PAGES);
         row_valid_ff  <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            total_ff <= csr_wr_data;
         end
         if (ram_wr_en) begin
            row_valid_ff[rd_word_ff] <= 1'b1;
         end
      end
      cmd_ff     <= cmd_in;
      word_ff    <= word_in;
      rd_word_ff <= rd_word_in;
      bit_ff     <= bit_in;
      if (ram_rd_en) begin
         rd_valid_ff <= row_valid_ff[ram_rd_addr];
      end
      if (rsp_strobe_in) begin
         rsp_status_ff <= rsp_status_in;
         rsp_addr_ff   <= rsp_addr_in;
         rsp_used_ff   <= used_in;
         rsp_free_ff   <= (used_in < total_eff) ? total_eff - used_in : '0;
      end
   end

   bpa_ram #(
      .WIDTH (BITS_PER_WORD),
      .DEPTH (WORD_COUNT)
   ) u_bitmap (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (rd_word_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_used_count     = rsp_used_ff;
   assign rsp_free_count     = rsp_free_ff;

   // a bitmap write always ends the item, so no read of the next item overlaps it
   `BPA_ASSERT_NEXT(a_write_ends_item, ram_wr_en, state_ff == S_IDLE, "write not followed by idle")
   `BPA_ASSERT_SAME(a_write_in_check, ram_wr_en, state_ff == S_CHECK, "bitmap write outside check")
   `BPA_ASSERT_SAME(a_used_bounded, 1'b1, used_ff <= COUNT_W'(MAX_PAGES), "used count overflow")
   `BPA_ASSERT_SAME(a_strobe_source, rsp_strobe_ff,
      $past(accept) || $past(state_ff == S_CHECK), "response without item")

endmodule
